// ----- sv/sdinit_pkg.sv -----
// Package for the SD card initialization and read sequencer.
// Holds the shared phase, operation, status and command types.
// No dependencies.
`timescale 1ns / 1ps

package sdinit_pkg;

    localparam int WordW      = 32;
    localparam int RcaW       = 16;
    localparam int TriesW     = 8;
    localparam int CmdIdxW    = 6;
    localparam int CfgIdxW    = 1;
    localparam int SectorShift = 9;

    localparam logic [11:0]      IfCondEcho   = 12'h1AA;
    localparam logic [WordW-1:0] IfCondArg    = 32'h0000_01AA;
    localparam logic [WordW-1:0] OpCondArg    = 32'h4010_0000;
    localparam logic [WordW-1:0] BusWidthArg  = 32'h0000_0002;
    localparam logic [TriesW-1:0] RetryLimitReset = 8'd100;

    localparam logic [CfgIdxW-1:0] CfgPartitionOffset = 1'b0;
    localparam logic [CfgIdxW-1:0] CfgRetryLimit      = 1'b1;

    localparam logic [CmdIdxW-1:0] CmdGoIdle      = 6'd0;
    localparam logic [CmdIdxW-1:0] CmdAllSendCid  = 6'd2;
    localparam logic [CmdIdxW-1:0] CmdSendRca     = 6'd3;
    localparam logic [CmdIdxW-1:0] CmdSetBusWidth = 6'd6;
    localparam logic [CmdIdxW-1:0] CmdSelect      = 6'd7;
    localparam logic [CmdIdxW-1:0] CmdIfCond      = 6'd8;
    localparam logic [CmdIdxW-1:0] CmdReadSingle  = 6'd17;
    localparam logic [CmdIdxW-1:0] CmdSdOpCond    = 6'd41;
    localparam logic [CmdIdxW-1:0] CmdAppCmd      = 6'd55;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_DONE  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_CMD0   = 4'd1,
        PH_CMD8   = 4'd2,
        PH_APP41  = 4'd3,
        PH_ACMD41 = 4'd4,
        PH_CMD2   = 4'd5,
        PH_CMD3   = 4'd6,
        PH_CMD7   = 4'd7,
        PH_APP6   = 4'd8,
        PH_ACMD6  = 4'd9,
        PH_READY  = 4'd10,
        PH_READ   = 4'd11,
        PH_FAILED = 4'd12
    } t_phase;

    typedef enum logic [1:0] {
        RSP_NONE   = 2'd0,
        RSP_R136   = 2'd1,
        RSP_R48    = 2'd2,
        RSP_R48B   = 2'd3
    } t_rsp_kind;

    typedef enum logic [1:0] {
        CLK_KEEP     = 2'd0,
        CLK_IDENT    = 2'd1,
        CLK_TRANSFER = 2'd2
    } t_clk_sel;

    typedef enum logic [2:0] {
        ST_BUSY       = 3'd0,
        ST_READY      = 3'd1,
        ST_INIT_FAIL  = 3'd2,
        ST_READ_DONE  = 3'd3,
        ST_READ_ERROR = 3'd4,
        ST_NOT_READY  = 3'd5
    } t_status;

    typedef struct packed {
        logic               issue;
        logic [CmdIdxW-1:0] index;
        t_rsp_kind          kind;
        logic               check_crc;
        logic               check_index;
        logic               data_read;
        logic [WordW-1:0]   argument;
    } t_cmd;

    typedef struct packed {
        t_cmd     cmd;
        t_clk_sel clock_select;
        t_status  status;
        logic     high_capacity;
        logic     wide_bus;
    } t_result;

    typedef struct packed {
        t_phase            phase;
        logic [TriesW-1:0] op_cond_tries;
        logic [RcaW-1:0]   card_address;
        logic              block_addressed;
        logic              bus_is_wide;
    } t_seq_state;

endpackage

// ----- sv/sdinit_step.sv -----
// Combinational step of the sequencer: next card state and the result for one request.
// Depends on sdinit_pkg.
`timescale 1ns / 1ps

module sdinit_step (
    input  sdinit_pkg::t_seq_state              i_state,
    input  sdinit_pkg::t_op                     i_operation,
    input  logic                                i_command_ok,
    input  logic [sdinit_pkg::WordW-1:0]        i_response_word,
    input  logic [sdinit_pkg::WordW-1:0]        i_sector,
    input  logic [sdinit_pkg::WordW-1:0]        i_partition_offset,
    input  logic [sdinit_pkg::TriesW-1:0]       i_retry_limit,
    output sdinit_pkg::t_seq_state              o_state,
    output sdinit_pkg::t_result                 o_result
);

    function automatic sdinit_pkg::t_cmd mk_cmd(
        input logic [sdinit_pkg::CmdIdxW-1:0] idx,
        input sdinit_pkg::t_rsp_kind          kind,
        input logic                           crc,
        input logic                           chk,
        input logic                           data,
        input logic [sdinit_pkg::WordW-1:0]   arg
    );
        sdinit_pkg::t_cmd c;
        c.issue       = 1'b1;
        c.index       = idx;
        c.kind        = kind;
        c.check_crc   = crc;
        c.check_index = chk;
        c.data_read   = data;
        c.argument    = arg;
        return c;
    endfunction

    function automatic sdinit_pkg::t_status condition(input sdinit_pkg::t_phase ph);
        sdinit_pkg::t_status s;
        unique case (ph)
            sdinit_pkg::PH_IDLE:   s = sdinit_pkg::ST_NOT_READY;
            sdinit_pkg::PH_READY:  s = sdinit_pkg::ST_READY;
            sdinit_pkg::PH_FAILED: s = sdinit_pkg::ST_INIT_FAIL;
            default:               s = sdinit_pkg::ST_BUSY;
        endcase
        return s;
    endfunction

    logic [sdinit_pkg::TriesW-1:0] tries_inc;
    logic                          retry_fail;
    logic                          card_up;
    logic                          if_cond_bad;
    logic                          op_cond_done;
    logic [sdinit_pkg::WordW-1:0]  lba;
    logic [sdinit_pkg::WordW-1:0]  read_arg;
    logic [sdinit_pkg::WordW-1:0]  rca_arg;
    sdinit_pkg::t_cmd              app_cmd;

    assign tries_inc    = i_state.op_cond_tries + 8'd1;
    assign retry_fail   = (tries_inc >= i_retry_limit);
    assign card_up      = (i_state.phase == sdinit_pkg::PH_READY) ||
                          (i_state.phase == sdinit_pkg::PH_READ);
    assign if_cond_bad  = i_command_ok && (i_response_word[11:0] != sdinit_pkg::IfCondEcho);
    assign op_cond_done = i_command_ok && i_response_word[31];
    assign lba          = i_partition_offset + i_sector;
    assign read_arg     = i_state.block_addressed ? lba :
                          {lba[sdinit_pkg::WordW-1-sdinit_pkg::SectorShift:0],
                           {sdinit_pkg::SectorShift{1'b0}}};
    assign rca_arg      = {i_state.card_address, {sdinit_pkg::RcaW{1'b0}}};
    assign app_cmd      = mk_cmd(sdinit_pkg::CmdAppCmd, sdinit_pkg::RSP_R48,
                                 1'b1, 1'b1, 1'b0, rca_arg);

    always_comb begin
        o_state = i_state;
        unique case (i_operation)
            sdinit_pkg::OP_START: begin
                o_state.phase           = sdinit_pkg::PH_CMD0;
                o_state.op_cond_tries   = '0;
                o_state.card_address    = '0;
                o_state.block_addressed = 1'b0;
                o_state.bus_is_wide     = 1'b0;
            end
            sdinit_pkg::OP_DONE: begin
                unique case (i_state.phase)
                    sdinit_pkg::PH_CMD0: o_state.phase = sdinit_pkg::PH_CMD8;
                    sdinit_pkg::PH_CMD8: begin
                        if (if_cond_bad) begin
                            o_state.phase = sdinit_pkg::PH_FAILED;
                        end else begin
                            o_state.block_addressed = 1'b0;
                            o_state.op_cond_tries   = '0;
                            o_state.phase           = sdinit_pkg::PH_APP41;
                        end
                    end
                    sdinit_pkg::PH_APP41: begin
                        if (i_command_ok) begin
                            o_state.phase = sdinit_pkg::PH_ACMD41;
                        end else begin
                            o_state.op_cond_tries = tries_inc;
                            o_state.phase = retry_fail ? sdinit_pkg::PH_FAILED
                                                       : sdinit_pkg::PH_APP41;
                        end
                    end
                    sdinit_pkg::PH_ACMD41: begin
                        if (op_cond_done) begin
                            o_state.block_addressed = i_response_word[30];
                            o_state.phase           = sdinit_pkg::PH_CMD2;
                        end else begin
                            o_state.op_cond_tries = tries_inc;
                            o_state.phase = retry_fail ? sdinit_pkg::PH_FAILED
                                                       : sdinit_pkg::PH_APP41;
                        end
                    end
                    sdinit_pkg::PH_CMD2: begin
                        o_state.phase = i_command_ok ? sdinit_pkg::PH_CMD3
                                                     : sdinit_pkg::PH_FAILED;
                    end
                    sdinit_pkg::PH_CMD3: begin
                        if (i_command_ok) begin
                            o_state.card_address = i_response_word[31:16];
                            o_state.phase        = sdinit_pkg::PH_CMD7;
                        end else begin
                            o_state.phase = sdinit_pkg::PH_FAILED;
                        end
                    end
                    sdinit_pkg::PH_CMD7: begin
                        o_state.phase = i_command_ok ? sdinit_pkg::PH_APP6
                                                     : sdinit_pkg::PH_FAILED;
                    end
                    sdinit_pkg::PH_APP6: begin
                        o_state.phase = i_command_ok ? sdinit_pkg::PH_ACMD6
                                                     : sdinit_pkg::PH_READY;
                    end
                    sdinit_pkg::PH_ACMD6: begin
                        if (i_command_ok) begin
                            o_state.bus_is_wide = 1'b1;
                        end
                        o_state.phase = sdinit_pkg::PH_READY;
                    end
                    sdinit_pkg::PH_READ: o_state.phase = sdinit_pkg::PH_READY;
                    default: ;
                endcase
            end
            sdinit_pkg::OP_READ: begin
                if (card_up && (i_state.phase != sdinit_pkg::PH_READ)) begin
                    o_state.phase = sdinit_pkg::PH_READ;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result               = '0;
        o_result.status        = condition(o_state.phase);
        o_result.high_capacity = o_state.block_addressed;
        o_result.wide_bus      = o_state.bus_is_wide;
        unique case (i_operation)
            sdinit_pkg::OP_START: begin
                o_result.cmd = mk_cmd(sdinit_pkg::CmdGoIdle, sdinit_pkg::RSP_NONE,
                                      1'b0, 1'b0, 1'b0, '0);
                o_result.clock_select = sdinit_pkg::CLK_IDENT;
                o_result.status       = sdinit_pkg::ST_BUSY;
            end
            sdinit_pkg::OP_DONE: begin
                unique case (i_state.phase)
                    sdinit_pkg::PH_CMD0: begin
                        o_result.cmd = mk_cmd(sdinit_pkg::CmdIfCond, sdinit_pkg::RSP_R48,
                                              1'b1, 1'b1, 1'b0, sdinit_pkg::IfCondArg);
                    end
                    sdinit_pkg::PH_CMD8: begin
                        if (!if_cond_bad) begin
                            o_result.cmd = app_cmd;
                        end
                    end
                    sdinit_pkg::PH_APP41: begin
                        if (i_command_ok) begin
                            o_result.cmd = mk_cmd(sdinit_pkg::CmdSdOpCond,
                                                  sdinit_pkg::RSP_R48, 1'b0, 1'b0, 1'b0,
                                                  sdinit_pkg::OpCondArg);
                        end else if (!retry_fail) begin
                            o_result.cmd = app_cmd;
                        end
                    end
                    sdinit_pkg::PH_ACMD41: begin
                        if (op_cond_done) begin
                            o_result.cmd = mk_cmd(sdinit_pkg::CmdAllSendCid,
                                                  sdinit_pkg::RSP_R136, 1'b1, 1'b0, 1'b0,
                                                  '0);
                        end else if (!retry_fail) begin
                            o_result.cmd = app_cmd;
                        end
                    end
                    sdinit_pkg::PH_CMD2: begin
                        if (i_command_ok) begin
                            o_result.cmd = mk_cmd(sdinit_pkg::CmdSendRca, sdinit_pkg::RSP_R48,
                                                  1'b1, 1'b1, 1'b0, '0);
                        end
                    end
                    sdinit_pkg::PH_CMD3: begin
                        if (i_command_ok) begin
                            o_result.cmd = mk_cmd(sdinit_pkg::CmdSelect, sdinit_pkg::RSP_R48B,
                                                  1'b1, 1'b1, 1'b0,
                                                  {i_response_word[31:16],
                                                   {sdinit_pkg::RcaW{1'b0}}});
                        end
                    end
                    sdinit_pkg::PH_CMD7: begin
                        if (i_command_ok) begin
                            o_result.cmd          = app_cmd;
                            o_result.clock_select = sdinit_pkg::CLK_TRANSFER;
                        end
                    end
                    sdinit_pkg::PH_APP6: begin
                        if (i_command_ok) begin
                            o_result.cmd = mk_cmd(sdinit_pkg::CmdSetBusWidth,
                                                  sdinit_pkg::RSP_R48, 1'b1, 1'b1, 1'b0,
                                                  sdinit_pkg::BusWidthArg);
                        end
                    end
                    sdinit_pkg::PH_READ: begin
                        o_result.status = i_command_ok ? sdinit_pkg::ST_READ_DONE
                                                       : sdinit_pkg::ST_READ_ERROR;
                    end
                    default: ;
                endcase
            end
            sdinit_pkg::OP_READ: begin
                if (!card_up) begin
                    o_result.status = sdinit_pkg::ST_NOT_READY;
                end else if (i_state.phase == sdinit_pkg::PH_READ) begin
                    o_result.status = sdinit_pkg::ST_BUSY;
                end else begin
                    o_result.cmd = mk_cmd(sdinit_pkg::CmdReadSingle, sdinit_pkg::RSP_R48,
                                          1'b1, 1'b1, 1'b1, read_arg);
                    o_result.status = sdinit_pkg::ST_BUSY;
                end
            end
            default: ;
        endcase
    end

endmodule

// ----- sv/sdinit_out_reg.sv -----
// Result register of the sequencer with its valid/ready handshake.
// Depends on sdinit_pkg.
`timescale 1ns / 1ps

module sdinit_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sdinit_pkg::t_result i_result,
    output logic                o_valid,
    input  logic                i_ready,
    output sdinit_pkg::t_result o_result
);

    logic                r_valid;
    sdinit_pkg::t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- sv/sd_card_init_read_sequencer_core.sv -----
// Top level of the SD card initialization and read sequencer.
// Depends on sdinit_pkg, sdinit_step and sdinit_out_reg.
`timescale 1ns / 1ps

//  Channel   Handshake                  Payload
//  in        i_in_valid / o_in_ready    operation, command_ok, response_word, sector
//  out       o_out_valid / i_out_ready  command fields, clock_select, status, flags
//  cfg       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each request gives exactly one result, passed on through the result register.
// A request is taken every cycle while results are being drained.
// The input register and the result register both stall when the result is not taken.
// Reset clears all card state, sets the retry limit to 100 and the offset to zero.

module sd_card_init_read_sequencer_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_operation,
    input  logic                                i_command_ok,
    input  logic [sdinit_pkg::WordW-1:0]        i_response_word,
    input  logic [sdinit_pkg::WordW-1:0]        i_sector,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_issue_command,
    output logic [sdinit_pkg::CmdIdxW-1:0]      o_command_index,
    output logic [1:0]                          o_response_kind,
    output logic                                o_check_crc,
    output logic                                o_check_index,
    output logic                                o_data_read,
    output logic [sdinit_pkg::WordW-1:0]        o_argument,
    output logic [1:0]                          o_clock_select,
    output logic [2:0]                          o_status,
    output logic                                o_high_capacity,
    output logic                                o_wide_bus,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [sdinit_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [sdinit_pkg::WordW-1:0]        i_cfg_data
);

    logic                              r_in_valid;
    sdinit_pkg::t_op                   r_operation;
    logic                              r_command_ok;
    logic [sdinit_pkg::WordW-1:0]      r_response_word;
    logic [sdinit_pkg::WordW-1:0]      r_sector;
    logic [sdinit_pkg::WordW-1:0]      r_partition_offset;
    logic [sdinit_pkg::TriesW-1:0]     r_retry_limit;
    sdinit_pkg::t_seq_state            r_state;
    sdinit_pkg::t_seq_state            n_state;
    sdinit_pkg::t_result               step_result;
    sdinit_pkg::t_result               out_result;
    logic                              out_ready;
    logic                              advance;

    assign advance     = r_in_valid && out_ready;
    assign o_in_ready  = !r_in_valid || out_ready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_operation     <= sdinit_pkg::t_op'(i_operation);
            r_command_ok    <= i_command_ok;
            r_response_word <= i_response_word;
            r_sector        <= i_sector;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partition_offset <= '0;
            r_retry_limit      <= sdinit_pkg::RetryLimitReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sdinit_pkg::CfgPartitionOffset: r_partition_offset <= i_cfg_data;
                sdinit_pkg::CfgRetryLimit:
                    r_retry_limit <= i_cfg_data[sdinit_pkg::TriesW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= sdinit_pkg::PH_IDLE;
            r_state.op_cond_tries   <= '0;
            r_state.card_address    <= '0;
            r_state.block_addressed <= 1'b0;
            r_state.bus_is_wide     <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    sdinit_step u_step (
        .i_state            (r_state),
        .i_operation        (r_operation),
        .i_command_ok       (r_command_ok),
        .i_response_word    (r_response_word),
        .i_sector           (r_sector),
        .i_partition_offset (r_partition_offset),
        .i_retry_limit      (r_retry_limit),
        .o_state            (n_state),
        .o_result           (step_result)
    );

    sdinit_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .o_ready  (out_ready),
        .i_result (step_result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_issue_command = out_result.cmd.issue;
    assign o_command_index = out_result.cmd.index;
    assign o_response_kind = out_result.cmd.kind;
    assign o_check_crc     = out_result.cmd.check_crc;
    assign o_check_index   = out_result.cmd.check_index;
    assign o_data_read     = out_result.cmd.data_read;
    assign o_argument      = out_result.cmd.argument;
    assign o_clock_select  = out_result.clock_select;
    assign o_status        = out_result.status;
    assign o_high_capacity = out_result.high_capacity;
    assign o_wide_bus      = out_result.wide_bus;

endmodule

// ----- test/sd_card_init_read_sequencer_core_tb.sv -----
// Self-checking testbench for sd_card_init_read_sequencer_core.
// A directed table and random init/read sessions are checked against a local sequencer model.
// Depends on sdinit_pkg and the core RTL.
`timescale 1ns / 1ps

module sd_card_init_read_sequencer_core_tb;

    typedef struct {
        sdinit_pkg::t_op     op;
        logic                ok;
        logic [31:0]         resp;
        logic [31:0]         sec;
        bit                  typed;
        sdinit_pkg::t_result want;
    } t_plan_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_in_valid;
    logic                             o_in_ready;
    logic [1:0]                       i_operation;
    logic                             i_command_ok;
    logic [sdinit_pkg::WordW-1:0]     i_response_word;
    logic [sdinit_pkg::WordW-1:0]     i_sector;
    logic                             o_out_valid;
    logic                             i_out_ready;
    logic                             o_issue_command;
    logic [sdinit_pkg::CmdIdxW-1:0]   o_command_index;
    logic [1:0]                       o_response_kind;
    logic                             o_check_crc;
    logic                             o_check_index;
    logic                             o_data_read;
    logic [sdinit_pkg::WordW-1:0]     o_argument;
    logic [1:0]                       o_clock_select;
    logic [2:0]                       o_status;
    logic                             o_high_capacity;
    logic                             o_wide_bus;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [sdinit_pkg::CfgIdxW-1:0]   i_cfg_index;
    logic [sdinit_pkg::WordW-1:0]     i_cfg_data;

    sdinit_pkg::t_phase               seq_phase;
    logic [sdinit_pkg::TriesW-1:0]    op_cond_tries;
    logic [sdinit_pkg::RcaW-1:0]      rca_latched;
    logic                             block_addr;
    logic                             bus_wide;
    logic                             card_is_ready;
    logic [sdinit_pkg::WordW-1:0]     cfg_offset;
    logic [sdinit_pkg::TriesW-1:0]    cfg_retry_limit;

    sdinit_pkg::t_result              commands_due[$];
    int                               mismatches;
    int                               holds_asked;
    int                               holds_done;
    int                               hold_left;
    bit                               no_gaps;

    sd_card_init_read_sequencer_core u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_command_ok    (i_command_ok),
        .i_response_word (i_response_word),
        .i_sector        (i_sector),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_issue_command (o_issue_command),
        .o_command_index (o_command_index),
        .o_response_kind (o_response_kind),
        .o_check_crc     (o_check_crc),
        .o_check_index   (o_check_index),
        .o_data_read     (o_data_read),
        .o_argument      (o_argument),
        .o_clock_select  (o_clock_select),
        .o_status        (o_status),
        .o_high_capacity (o_high_capacity),
        .o_wide_bus      (o_wide_bus),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("sd_card_init_read_sequencer_core_tb: FAIL");
        $finish;
    end

    function automatic sdinit_pkg::t_cmd make_cmd(logic [sdinit_pkg::CmdIdxW-1:0] idx,
                                                  sdinit_pkg::t_rsp_kind kind, logic crc,
                                                  logic chk, logic data,
                                                  logic [sdinit_pkg::WordW-1:0] arg);
        sdinit_pkg::t_cmd c;
        c.issue       = 1'b1;
        c.index       = idx;
        c.kind        = kind;
        c.check_crc   = crc;
        c.check_index = chk;
        c.data_read   = data;
        c.argument    = arg;
        return c;
    endfunction

    function automatic sdinit_pkg::t_status current_condition();
        case (seq_phase)
            sdinit_pkg::PH_IDLE:   return sdinit_pkg::ST_NOT_READY;
            sdinit_pkg::PH_READY:  return sdinit_pkg::ST_READY;
            sdinit_pkg::PH_FAILED: return sdinit_pkg::ST_INIT_FAIL;
            default:               return sdinit_pkg::ST_BUSY;
        endcase
    endfunction

    function automatic void abort_init();
        seq_phase     = sdinit_pkg::PH_FAILED;
        card_is_ready = 1'b0;
    endfunction

    function automatic sdinit_pkg::t_cmd app_command();
        return make_cmd(sdinit_pkg::CmdAppCmd, sdinit_pkg::RSP_R48, 1'b1, 1'b1, 1'b0,
                        {rca_latched, 16'h0});
    endfunction

    function automatic sdinit_pkg::t_cmd retry_op_cond();
        op_cond_tries = op_cond_tries + 1'b1;
        if (op_cond_tries >= cfg_retry_limit) begin
            abort_init();
            return '0;
        end
        seq_phase = sdinit_pkg::PH_APP41;
        return app_command();
    endfunction

    function automatic sdinit_pkg::t_result advance_sequencer(
        sdinit_pkg::t_op op, logic ok, logic [sdinit_pkg::WordW-1:0] resp,
        logic [sdinit_pkg::WordW-1:0] sec);
        sdinit_pkg::t_result          r;
        logic [sdinit_pkg::WordW-1:0] lba;
        bit                           read_closed;
        r = '0;
        read_closed = 1'b0;
        case (op)
            sdinit_pkg::OP_START: begin
                op_cond_tries  = '0;
                rca_latched    = '0;
                block_addr     = 1'b0;
                bus_wide       = 1'b0;
                card_is_ready  = 1'b0;
                r.cmd          = make_cmd(sdinit_pkg::CmdGoIdle, sdinit_pkg::RSP_NONE,
                                          1'b0, 1'b0, 1'b0, '0);
                r.clock_select = sdinit_pkg::CLK_IDENT;
                seq_phase      = sdinit_pkg::PH_CMD0;
                r.status       = sdinit_pkg::ST_BUSY;
            end
            sdinit_pkg::OP_DONE: begin
                case (seq_phase)
                    sdinit_pkg::PH_CMD0: begin
                        r.cmd = make_cmd(sdinit_pkg::CmdIfCond, sdinit_pkg::RSP_R48,
                                         1'b1, 1'b1, 1'b0, sdinit_pkg::IfCondArg);
                        seq_phase = sdinit_pkg::PH_CMD8;
                    end
                    sdinit_pkg::PH_CMD8: begin
                        if (ok && resp[11:0] != sdinit_pkg::IfCondEcho) begin
                            abort_init();
                        end else begin
                            block_addr    = 1'b0;
                            op_cond_tries = '0;
                            r.cmd         = app_command();
                            seq_phase     = sdinit_pkg::PH_APP41;
                        end
                    end
                    sdinit_pkg::PH_APP41: begin
                        if (ok) begin
                            r.cmd = make_cmd(sdinit_pkg::CmdSdOpCond, sdinit_pkg::RSP_R48,
                                             1'b0, 1'b0, 1'b0, sdinit_pkg::OpCondArg);
                            seq_phase = sdinit_pkg::PH_ACMD41;
                        end else begin
                            r.cmd = retry_op_cond();
                        end
                    end
                    sdinit_pkg::PH_ACMD41: begin
                        if (ok && resp[31]) begin
                            block_addr = resp[30];
                            r.cmd = make_cmd(sdinit_pkg::CmdAllSendCid, sdinit_pkg::RSP_R136,
                                             1'b1, 1'b0, 1'b0, '0);
                            seq_phase = sdinit_pkg::PH_CMD2;
                        end else begin
                            r.cmd = retry_op_cond();
                        end
                    end
                    sdinit_pkg::PH_CMD2: begin
                        if (!ok) begin
                            abort_init();
                        end else begin
                            r.cmd = make_cmd(sdinit_pkg::CmdSendRca, sdinit_pkg::RSP_R48,
                                             1'b1, 1'b1, 1'b0, '0);
                            seq_phase = sdinit_pkg::PH_CMD3;
                        end
                    end
                    sdinit_pkg::PH_CMD3: begin
                        if (!ok) begin
                            abort_init();
                        end else begin
                            rca_latched = resp[31:16];
                            r.cmd = make_cmd(sdinit_pkg::CmdSelect, sdinit_pkg::RSP_R48B,
                                             1'b1, 1'b1, 1'b0, {rca_latched, 16'h0});
                            seq_phase = sdinit_pkg::PH_CMD7;
                        end
                    end
                    sdinit_pkg::PH_CMD7: begin
                        if (!ok) begin
                            abort_init();
                        end else begin
                            r.cmd          = app_command();
                            r.clock_select = sdinit_pkg::CLK_TRANSFER;
                            seq_phase      = sdinit_pkg::PH_APP6;
                        end
                    end
                    sdinit_pkg::PH_APP6: begin
                        if (ok) begin
                            r.cmd = make_cmd(sdinit_pkg::CmdSetBusWidth, sdinit_pkg::RSP_R48,
                                             1'b1, 1'b1, 1'b0, sdinit_pkg::BusWidthArg);
                            seq_phase = sdinit_pkg::PH_ACMD6;
                        end else begin
                            seq_phase     = sdinit_pkg::PH_READY;
                            card_is_ready = 1'b1;
                        end
                    end
                    sdinit_pkg::PH_ACMD6: begin
                        if (ok) begin
                            bus_wide = 1'b1;
                        end
                        seq_phase     = sdinit_pkg::PH_READY;
                        card_is_ready = 1'b1;
                    end
                    sdinit_pkg::PH_READ: begin
                        seq_phase   = sdinit_pkg::PH_READY;
                        r.status    = ok ? sdinit_pkg::ST_READ_DONE
                                         : sdinit_pkg::ST_READ_ERROR;
                        read_closed = 1'b1;
                    end
                    default: ;
                endcase
                if (!read_closed) begin
                    r.status = current_condition();
                end
            end
            sdinit_pkg::OP_READ: begin
                if (!card_is_ready) begin
                    r.status = sdinit_pkg::ST_NOT_READY;
                end else if (seq_phase == sdinit_pkg::PH_READ) begin
                    r.status = sdinit_pkg::ST_BUSY;
                end else begin
                    lba = cfg_offset + sec;
                    r.cmd = make_cmd(sdinit_pkg::CmdReadSingle, sdinit_pkg::RSP_R48,
                                     1'b1, 1'b1, 1'b1,
                                     block_addr ? lba : lba << sdinit_pkg::SectorShift);
                    seq_phase = sdinit_pkg::PH_READ;
                    r.status  = sdinit_pkg::ST_BUSY;
                end
            end
            default: r.status = current_condition();
        endcase
        r.high_capacity = block_addr;
        r.wide_bus      = bus_wide;
        return r;
    endfunction

    task automatic push_request(sdinit_pkg::t_op op, logic ok,
                                logic [sdinit_pkg::WordW-1:0] resp,
                                logic [sdinit_pkg::WordW-1:0] sec, bit typed,
                                sdinit_pkg::t_result want);
        sdinit_pkg::t_result predicted;
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_command_ok    <= ok;
        i_response_word <= resp;
        i_sector        <= sec;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = advance_sequencer(op, ok, resp, sec);
        commands_due.push_back(typed ? want : predicted);
        if (!no_gaps && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
    endtask

    task automatic apply_settings(logic [sdinit_pkg::WordW-1:0] offset,
                                  logic [sdinit_pkg::TriesW-1:0] limit);
        while (commands_due.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= sdinit_pkg::CfgPartitionOffset;
        i_cfg_data  <= offset;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_offset = offset;
        i_cfg_index <= sdinit_pkg::CfgRetryLimit;
        i_cfg_data  <= {{(sdinit_pkg::WordW - sdinit_pkg::TriesW){1'b0}}, limit};
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_retry_limit = limit;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic compare_field(string label, logic [sdinit_pkg::WordW-1:0] want,
                                 logic [sdinit_pkg::WordW-1:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done  <= holds_asked;
            hold_left   <= 60;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_gaps || $urandom_range(99) >= 19;
        end
    end

    always @(posedge i_clk) begin
        sdinit_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (commands_due.size() == 0) begin
                mismatches++;
                $display("%0t: result arrived with no request waiting", $time);
            end else begin
                want = commands_due.pop_front();
                compare_field("issue_command", want.cmd.issue, o_issue_command);
                compare_field("command_index", want.cmd.index, o_command_index);
                compare_field("response_kind", want.cmd.kind, o_response_kind);
                compare_field("check_crc", want.cmd.check_crc, o_check_crc);
                compare_field("check_index", want.cmd.check_index, o_check_index);
                compare_field("data_read", want.cmd.data_read, o_data_read);
                compare_field("argument", want.cmd.argument, o_argument);
                compare_field("clock_select", want.clock_select, o_clock_select);
                compare_field("status", want.status, o_status);
                compare_field("high_capacity", want.high_capacity, o_high_capacity);
                compare_field("wide_bus", want.wide_bus, o_wide_bus);
            end
        end
    end

    initial begin
        t_plan_row                     directed[$];
        sdinit_pkg::t_result           not_ready_result;
        sdinit_pkg::t_result           init_fail_result;
        sdinit_pkg::t_result           go_idle_result;
        logic [sdinit_pkg::WordW-1:0]  offsets[6];
        logic [sdinit_pkg::TriesW-1:0] limits[6];
        sdinit_pkg::t_op               op;
        logic                          ok;
        logic [sdinit_pkg::WordW-1:0]  resp;
        logic [sdinit_pkg::WordW-1:0]  sec;
        int                            roll;
        int                            items_sent;

        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_operation     <= sdinit_pkg::OP_NONE;
        i_command_ok    <= 1'b0;
        i_response_word <= '0;
        i_sector        <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= sdinit_pkg::CfgPartitionOffset;
        i_cfg_data      <= '0;
        mismatches      = 0;
        holds_asked     = 0;
        no_gaps         = 1'b0;
        items_sent      = 0;

        seq_phase       = sdinit_pkg::PH_IDLE;
        op_cond_tries   = '0;
        rca_latched     = '0;
        block_addr      = 1'b0;
        bus_wide        = 1'b0;
        card_is_ready   = 1'b0;
        cfg_offset      = '0;
        cfg_retry_limit = sdinit_pkg::RetryLimitReset;

        not_ready_result        = '0;
        not_ready_result.status = sdinit_pkg::ST_NOT_READY;
        init_fail_result        = '0;
        init_fail_result.status = sdinit_pkg::ST_INIT_FAIL;
        go_idle_result          = '0;
        go_idle_result.cmd      = make_cmd(sdinit_pkg::CmdGoIdle, sdinit_pkg::RSP_NONE,
                                           1'b0, 1'b0, 1'b0, '0);
        go_idle_result.clock_select = sdinit_pkg::CLK_IDENT;
        go_idle_result.status   = sdinit_pkg::ST_BUSY;

        directed.push_back('{sdinit_pkg::OP_READ,  1'b1, 32'h0, 32'hFFFF_FFFF,
                             1'b1, not_ready_result});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'hFFFF_FFFF, 32'h0,
                             1'b1, not_ready_result});
        directed.push_back('{sdinit_pkg::OP_NONE,  1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             1'b1, not_ready_result});
        directed.push_back('{sdinit_pkg::OP_START, 1'b0, 32'h0, 32'h0,
                             1'b1, go_idle_result});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b0, 32'h0, 32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'h0000_0ABC, 32'h0,
                             1'b1, init_fail_result});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'h0, 32'h0,
                             1'b1, init_fail_result});
        directed.push_back('{sdinit_pkg::OP_READ,  1'b1, 32'h0, 32'h1234_5678,
                             1'b1, not_ready_result});
        directed.push_back('{sdinit_pkg::OP_START, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             1'b1, go_idle_result});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b0, 32'h0,         32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b0, 32'h0,         32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'h0,         32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'h4000_0000, 32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'h0,         32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'hC0FF_FFFF, 32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'hFFFF_FFFF, 32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'hFFFF_0000, 32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'h0,         32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'h0,         32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b1, 32'h0,         32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_READ,  1'b0, 32'h0, 32'hFFFF_FFFF, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_READ,  1'b0, 32'h0,         32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_DONE,  1'b0, 32'h0,         32'h0, 1'b0, '0});
        directed.push_back('{sdinit_pkg::OP_START, 1'b0, 32'h0, 32'h0,
                             1'b1, go_idle_result});

        offsets = '{32'h0, 32'hFFFF_FFFF, $urandom, $urandom, 32'h0000_0001, $urandom};
        limits  = '{8'd255, 8'd1, 8'd0, 8'd3, 8'($urandom_range(2, 10)),
                    sdinit_pkg::RetryLimitReset};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) begin
            push_request(directed[k].op, directed[k].ok, directed[k].resp, directed[k].sec,
                         directed[k].typed, directed[k].want);
        end
        i_in_valid <= 1'b0;

        for (int p = 0; p < 6; p++) begin
            apply_settings(offsets[p], limits[p]);
            repeat (165) begin
                roll = $urandom_range(99);
                ok   = $urandom_range(99) < 80;
                resp = $urandom;
                sec  = $urandom;
                if ($urandom_range(99) < 10) begin
                    sec = $urandom_range(1) ? '1 : '0;
                end
                op = sdinit_pkg::OP_DONE;
                if (roll < 5) begin
                    op = sdinit_pkg::t_op'($urandom_range(3));
                end else if (roll < 8) begin
                    op = sdinit_pkg::OP_START;
                end else begin
                    case (seq_phase)
                        sdinit_pkg::PH_IDLE, sdinit_pkg::PH_FAILED: op = sdinit_pkg::OP_START;
                        sdinit_pkg::PH_CMD8: begin
                            if ($urandom_range(99) < 85) begin
                                resp[11:0] = sdinit_pkg::IfCondEcho;
                            end
                        end
                        sdinit_pkg::PH_ACMD41: begin
                            ok       = $urandom_range(99) < 90;
                            resp[31] = $urandom_range(99) < 60;
                        end
                        sdinit_pkg::PH_CMD2, sdinit_pkg::PH_CMD3, sdinit_pkg::PH_CMD7:
                            ok = $urandom_range(99) < 95;
                        sdinit_pkg::PH_READY: op = sdinit_pkg::OP_READ;
                        sdinit_pkg::PH_READ: begin
                            if ($urandom_range(99) < 10) begin
                                op = sdinit_pkg::OP_READ;
                            end
                        end
                        default: ;
                    endcase
                end
                if (items_sent == 100 || items_sent == 700) begin
                    holds_asked++;
                end
                no_gaps = items_sent >= 400 && items_sent < 560;
                push_request(op, ok, resp, sec, 1'b0, '0);
                items_sent++;
            end
            i_in_valid <= 1'b0;
        end

        while (commands_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("sd_card_init_read_sequencer_core_tb: PASS");
        end else begin
            $display("sd_card_init_read_sequencer_core_tb: FAIL");
        end
        $finish;
    end

endmodule
